>>> src/bmf_pkg.sv
// Shared constants and types for the box mean filter.
`timescale 1ns / 1ps
package bmf_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_RADIUS = 7;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_ROWS  = 2 * MAX_RADIUS + 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(LINE_ROWS);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int STORE_DEPTH = LINE_ROWS * MAX_WIDTH;
  localparam int NUM_CH     = 4;
  localparam int SUM_W      = 16;
  localparam int DIV_CELLS  = 8;

  localparam logic [7:0] REG_IMAGE_WIDTH   = 8'd0;
  localparam logic [7:0] REG_IMAGE_HEIGHT  = 8'd1;
  localparam logic [7:0] REG_CHANNEL_COUNT = 8'd2;
  localparam logic [7:0] REG_WINDOW_RADIUS = 8'd3;

  localparam logic OP_PIXEL = 1'b0;

  typedef struct packed {
    logic                         valid;
    logic                         last;
    logic [7:0]                   count;
    logic [NUM_CH-1:0][SUM_W-1:0] rem;
    logic [NUM_CH-1:0][7:0]       quo;
  } div_stage_t;
endpackage

>>> src/box_mean_filter_2d_top.sv
// Top level of the streaming 2D box mean filter.
`timescale 1ns / 1ps
// Streaming box mean filter. Pixels come in raster order, up to four 8-bit
// channels each; every pixel item writes its pixel into a 16-row line RAM, and once
// (radius+1) rows have gone by each item also yields the truncated mean of the
// edge-clipped window around an older pixel. Items are handled one at a time.
// An item that yields a result sums its N in-bounds window pixels (up to 225
// at radius 7), then divides: the single read port of the line RAM reads one
// pixel per cycle, and the divider is a chain of 8 cells, one quotient bit
// each. After the frame, send (radius+1)*width drain items (operation = 1)
// to flush; the final result carries last_pixel. The user must write the
// configuration through the cfg port only while idle, which the block does
// not enforce; the line RAM needs no clearing after reset.
module box_mean_filter_2d_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  in_chan0,
  input  logic [7:0]  in_chan1,
  input  logic [7:0]  in_chan2,
  input  logic [7:0]  in_chan3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_chan0,
  output logic [7:0]  out_chan1,
  output logic [7:0]  out_chan2,
  output logic [7:0]  out_chan3,
  output logic        last_pixel
);
  import bmf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_FEED  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // config registers
  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  channel_count;
  logic [2:0]  window_radius;

  // clamped/derived from config
  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic [2:0]  nch;
  logic [23:0] frame;
  logic [14:0] lag;

  logic [2:0]  state;
  logic [23:0] k;
  logic [COL_W-1:0] wr_col;
  logic [ROW_W-1:0] wr_row;
  logic [12:0] out_i;
  logic [COL_W-1:0] out_j;
  logic        op_r;
  logic [31:0] data_r;

  logic [12:0] ry, win_y1;
  logic [COL_W-1:0] rx, win_x0, win_x1;
  logic [7:0]  win_count;
  logic        win_last;
  logic        rd_pending;
  logic [NUM_CH-1:0][SUM_W-1:0] sums;
  logic [NUM_CH-1:0][7:0] res_q;
  logic        res_last;
  logic [NUM_CH-1:0][7:0] out_q;

  // combinational helpers
  logic [23:0] total;
  logic        k_ge_total, k_lt_frame, k_ge_lag, wrap;
  logic [23:0] k_inc;
  logic [13:0] i_plus_r;
  logic [11:0] j_plus_r;
  logic [12:0] y0_c, y1_c;
  logic [COL_W-1:0] x0_c, x1_c;
  logic [3:0]  dy, dx;
  logic [7:0]  cnt_c;
  logic        last_c;
  logic        ram_we;
  logic [31:0] ram_wdata, ram_rdata;
  div_stage_t  feed, div_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 12'd640;
      image_height  <= 13'd480;
      channel_count <= 3'd3;
      window_radius <= 3'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[11:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
        REG_WINDOW_RADIUS: window_radius <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (image_width == '0) ? 12'd1 :
            (image_width > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : image_width;
    h_eff = (image_height == '0) ? 13'd1 :
            (image_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : image_height;
    nch   = (channel_count > 3'd4) ? 3'd4 : channel_count;
    frame = {12'b0, w_eff} * {11'b0, h_eff};
    lag   = ({12'b0, window_radius} + 15'd1) * {3'b0, w_eff};
  end

  always_comb begin
    total      = frame + {9'b0, lag};
    k_ge_total = (k >= total);
    k_lt_frame = (k < frame);
    k_ge_lag   = (k >= {9'b0, lag});
    k_inc      = k + 24'd1;
    wrap       = (k_inc >= total);
    i_plus_r   = {1'b0, out_i} + {11'b0, window_radius};
    y1_c = (i_plus_r < {1'b0, h_eff}) ? i_plus_r[12:0] : h_eff - 13'd1;
    y0_c = (out_i >= {10'b0, window_radius}) ? out_i - {10'b0, window_radius} : '0;
    j_plus_r   = {1'b0, out_j} + {9'b0, window_radius};
    x1_c = (j_plus_r < w_eff) ? j_plus_r[COL_W-1:0] : COL_W'(w_eff - 12'd1);
    x0_c = ({1'b0, out_j} >= {9'b0, window_radius}) ?
           COL_W'({1'b0, out_j} - {9'b0, window_radius}) : '0;
    dy     = 4'(y1_c - y0_c) + 4'd1;
    dx     = 4'(x1_c - x0_c) + 4'd1;
    cnt_c  = {4'b0, dy} * {4'b0, dx};
    last_c = (out_i == h_eff - 13'd1) && ({1'b0, out_j} == w_eff - 12'd1);
    ram_we = (state == S_SETUP) && !k_ge_total && k_lt_frame;
    ram_wdata = (op_r == OP_PIXEL) ? data_r : '0;
  end

  bmf_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({wr_row, wr_col}),
    .wdata (ram_wdata),
    .raddr ({ry[ROW_W-1:0], rx}),
    .rdata (ram_rdata)
  );

  always_comb begin
    feed.valid = (state == S_FEED);
    feed.last  = win_last;
    feed.count = win_count;
    feed.rem   = sums;
    feed.quo   = '0;
  end

  bmf_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (feed),
    .dout (div_out)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= operation;
      data_r <= {in_chan3, in_chan2, in_chan1, in_chan0};
    end
    if (rd_pending) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c] <= sums[c] + {8'b0, ram_rdata[8*c +: 8]};
      end
    end
    if (state == S_SETUP) begin
      sums      <= '0;
      ry        <= y0_c;
      rx        <= x0_c;
      win_y1    <= y1_c;
      win_x0    <= x0_c;
      win_x1    <= x1_c;
      win_count <= cnt_c;
      win_last  <= last_c;
    end
    if (state == S_READ) begin
      if (rx == win_x1) begin
        rx <= win_x0;
        ry <= ry + 13'd1;
      end else begin
        rx <= rx + COL_W'(1);
      end
    end
    if (state == S_DIV && div_out.valid) begin
      res_q    <= div_out.quo;
      res_last <= div_out.last;
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_q[c] <= (3'(c) < nch) ? res_q[c] : 8'd0;
      end
      last_pixel <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      k          <= '0;
      wr_col     <= '0;
      wr_row     <= '0;
      out_i      <= '0;
      out_j      <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= (state == S_READ);
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (k_ge_total || wrap) begin
            k      <= '0;
            wr_col <= '0;
            wr_row <= '0;
            out_i  <= '0;
            out_j  <= '0;
          end else begin
            k <= k_inc;
            if (k_lt_frame) begin
              if ({1'b0, wr_col} == w_eff - 12'd1) begin
                wr_col <= '0;
                wr_row <= wr_row + ROW_W'(1);
              end else begin
                wr_col <= wr_col + COL_W'(1);
              end
            end
            if (k_ge_lag) begin
              if ({1'b0, out_j} == w_eff - 12'd1) begin
                out_j <= '0;
                out_i <= out_i + 13'd1;
              end else begin
                out_j <= out_j + COL_W'(1);
              end
            end
          end
          if (!k_ge_total && k_ge_lag) begin
            state <= S_READ;
          end else begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (rx == win_x1 && ry == win_y1) begin
            state <= S_LAST;
          end
        end
        S_LAST: state <= S_FEED;
        S_FEED: state <= S_DIV;
        S_DIV: begin
          if (div_out.valid) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_chan0 = out_q[0];
  assign out_chan1 = out_q[1];
  assign out_chan2 = out_q[2];
  assign out_chan3 = out_q[3];

  // divider result only shows up while the sequencer waits for it
  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_out.valid |-> state == S_DIV)
    else $error("divider result outside wait state");

  // line RAM writes only during item setup
  a_we_setup: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_SETUP)
    else $error("line store written outside setup");

  // a window always holds at least one pixel
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    feed.valid |-> feed.count != 8'd0)
    else $error("zero pixel count fed to divider");
endmodule

>>> src/bmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/bmf_div_cell.sv
// One quotient-bit cell of the divider chain, all channels side by side.
`timescale 1ns / 1ps
module bmf_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  bmf_pkg::div_stage_t din,
  output bmf_pkg::div_stage_t dout
);
  import bmf_pkg::*;

  logic [SUM_W-1:0] dshift;
  div_stage_t       nxt;
  logic [SUM_W-1:0] diff;

  always_comb begin
    dshift = {1'b0, din.count, 7'b0};
    nxt = din;
    diff = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (din.rem[c] >= dshift) begin
        diff = din.rem[c] - dshift;
        nxt.quo[c] = {din.quo[c][6:0], 1'b1};
      end else begin
        diff = din.rem[c];
        nxt.quo[c] = {din.quo[c][6:0], 1'b0};
      end
      nxt.rem[c] = {diff[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.last  <= nxt.last;
    dout.count <= nxt.count;
    dout.rem   <= nxt.rem;
    dout.quo   <= nxt.quo;
  end
endmodule

>>> src/bmf_divider.sv
// Divider: a chain of quotient-bit cells, one bit per cell, MSB first.
`timescale 1ns / 1ps
module bmf_divider (
  input  logic                clk,
  input  logic                rst,
  input  bmf_pkg::div_stage_t din,
  output bmf_pkg::div_stage_t dout
);
  import bmf_pkg::*;

  div_stage_t link [DIV_CELLS+1];

  assign link[0] = din;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
    bmf_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (link[g]),
      .dout (link[g+1])
    );
  end

  assign dout = link[DIV_CELLS];
endmodule
